// File: sv/radar_pulse_tag_checker_combiner_top_defines.svh
// Assertion macros shared by the pulse tag checker and combiner RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef RADAR_PULSE_TAG_CHECKER_COMBINER_TOP_DEFINES_SVH
`define RADAR_PULSE_TAG_CHECKER_COMBINER_TOP_DEFINES_SVH
`ifndef SYNTH
`define RPTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RPTC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RPTC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RPTC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: sv/rptc_pkg.sv
// Package for the pulse tag checker and combiner: constants, codes, command
// and status structs and the saturation function. Depends on nothing.
package rptc_pkg;

  localparam int unsigned MAX_GATES_DEF = 1024;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned DIV_W         = 33;
  localparam int unsigned DIV_CNT_W     = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd33;

  localparam logic [CFG_IDX_W-1:0] REG_INTEGRATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_RUN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUMS      = 3'd4;

  typedef logic [2:0] kind_t;
  localparam kind_t K_TAG_PLAIN = 3'd0;
  localparam kind_t K_TAG_INT   = 3'd1;
  localparam kind_t K_EVEN      = 3'd2;
  localparam kind_t K_ODD_I     = 3'd3;
  localparam kind_t K_ODD_Q     = 3'd4;
  localparam kind_t K_GATE      = 3'd5;

  typedef struct packed {
    logic accept;
    logic cap_even;
    logic load_i;
    logic load_q;
    logic div_step;
    logic store_i;
    logic store_q;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  div_done;
    logic  out_free;
  } dp_stat_t;

  function automatic logic [15:0] sat16(input logic neg, input logic [DIV_W-1:0] mag);
    logic [15:0] r;
    if (neg) begin
      if (mag > 33'd32768) r = 16'h8000;
      else r = 16'(~mag[15:0] + 16'd1);
    end else begin
      if (mag > 33'd32767) r = 16'h7fff;
      else r = mag[15:0];
    end
    return r;
  endfunction

endpackage

// File: sv/rptc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rptc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/rptc_ctrl.sv
// Controller of the pulse tag checker and combiner: sequences accept,
// even-word capture, the two divisions and the output load. Uses rptc_pkg.
`include "radar_pulse_tag_checker_combiner_top_defines.svh"
module rptc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rptc_pkg::dp_stat_t    stat_i,
  output rptc_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CAP  = 3'd1;
  localparam logic [2:0] S_LDI  = 3'd2;
  localparam logic [2:0] S_DIVI = 3'd3;
  localparam logic [2:0] S_LDQ  = 3'd4;
  localparam logic [2:0] S_DIVQ = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (stat_i.kind)
            rptc_pkg::K_ODD_I: state_d = S_CAP;
            rptc_pkg::K_ODD_Q: state_d = S_LDI;
            rptc_pkg::K_GATE:  state_d = S_OUT;
            default:           state_d = S_IDLE;
          endcase
        end
      end
      S_CAP: begin
        cmd_o.cap_even = 1'b1;
        state_d = S_IDLE;
      end
      S_LDI: begin
        cmd_o.load_i = 1'b1;
        state_d = S_DIVI;
      end
      S_DIVI: begin
        if (stat_i.div_done) begin
          cmd_o.store_i = 1'b1;
          state_d = S_LDQ;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_LDQ: begin
        cmd_o.load_q = 1'b1;
        state_d = S_DIVQ;
      end
      S_DIVQ: begin
        if (stat_i.div_done) begin
          cmd_o.store_q = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  `RPTC_ASSERT_IMP(a_step_not_done, clk_i, rst_ni, cmd_o.div_step, !stat_i.div_done)
  `RPTC_ASSERT_NXT(a_oddq_divides, clk_i, rst_ni,
                   cmd_o.accept && stat_i.kind == rptc_pkg::K_ODD_Q, cmd_o.load_i)
  `RPTC_ASSERT_IMP(a_accept_ready, clk_i, rst_ni, cmd_o.accept, in_ready_o)

endmodule

// File: sv/rptc_dp.sv
// Datapath of the pulse tag checker and combiner: config registers, record
// framing, tag checks, even store, divider and output register.
// Uses rptc_pkg and rptc_ram.
`include "radar_pulse_tag_checker_combiner_top_defines.svh"
module rptc_dp #(
  parameter int unsigned MaxGates = rptc_pkg::MAX_GATES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [rptc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rptc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [31:0]                       word_i,
  input  rptc_pkg::ctrl_cmd_t               cmd_i,
  output rptc_pkg::dp_stat_t                stat_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [9:0]                        out_gate_o,
  output logic [15:0]                       out_i_o,
  output logic [15:0]                       out_q_o,
  output logic                              out_last_o,
  output logic [31:0]                       out_sync_o,
  output logic [31:0]                       out_drop_o
);

  localparam int unsigned PW = $clog2(4 * MaxGates + 5);
  localparam int unsigned AW = $clog2(2 * MaxGates);

  logic        integ_q, free_q;
  logic [1:0]  chan_q;
  logic [10:0] gcnt_q;
  logic [15:0] scnt_q;

  logic [PW-1:0] pos_q, pos_d;
  logic          first_q;
  logic [29:0]   lseq_q;
  logic [31:0]   sync_q, drop_q;

  logic [12:0]   g_wide;
  logic [PW-1:0] g, hdr, len, pos, pos_inc, ebound, k, gate;
  rptc_pkg::kind_t kind;

  always_comb begin
    if (gcnt_q == 11'd0) g_wide = 13'd1;
    else if (13'(gcnt_q) > 13'(MaxGates)) g_wide = 13'(MaxGates);
    else g_wide = 13'(gcnt_q);
    g      = PW'(g_wide);
    hdr    = PW'(!free_q);
    len    = integ_q ? (PW'(4) + (g << 2)) : (hdr + g);
    pos    = (pos_q >= len) ? '0 : pos_q;
    pos_inc = pos + PW'(1);
    pos_d  = (pos_inc >= len) ? '0 : pos_inc;
    ebound = PW'(4) + (g << 1);
    k      = pos - ebound;
    if (integ_q) begin
      gate = k >> 1;
      if (pos < PW'(4)) kind = rptc_pkg::K_TAG_INT;
      else if (pos < ebound) kind = rptc_pkg::K_EVEN;
      else if (!k[0]) kind = rptc_pkg::K_ODD_I;
      else kind = rptc_pkg::K_ODD_Q;
    end else begin
      gate = pos - hdr;
      kind = (pos < hdr) ? rptc_pkg::K_TAG_PLAIN : rptc_pkg::K_GATE;
    end
  end

  logic [31:0] rdata;
  logic        ram_we;
  assign ram_we = cmd_i.accept && kind == rptc_pkg::K_EVEN;

  rptc_ram #(.Width(32), .Depth(2 * MaxGates)) u_even (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(pos - PW'(4))),
    .wdata_i (word_i),
    .re_i    (cmd_i.accept),
    .raddr_i (AW'(k)),
    .rdata_o (rdata)
  );

  logic [31:0] word_q, odd_i_q, even_i_q, even_q_q;
  logic [9:0]  gate_q;
  logic        last_q;
  logic [15:0] res_i_q, res_q_q;

  logic [rptc_pkg::DIV_W-1:0]     quo_q;
  logic [16:0]                    rem_q, rem_sh;
  logic [15:0]                    dvs_q;
  logic                           neg_q;
  logic [rptc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [32:0]                    sum, mag;
  logic [31:0]                    add_a, add_b;

  always_comb begin
    add_a  = cmd_i.load_i ? even_i_q : even_q_q;
    add_b  = cmd_i.load_i ? odd_i_q : word_q;
    sum    = {add_a[31], add_a} + {add_b[31], add_b};
    mag    = sum[32] ? (~sum + 33'd1) : sum;
    rem_sh = {rem_q[15:0], quo_q[32]};
  end

  logic        tag_sync, tag_drop, chan_ok;
  logic [29:0] seq;
  always_comb begin
    seq      = word_i[29:0];
    chan_ok  = word_i[31:30] == chan_q;
    tag_sync = 1'b0;
    tag_drop = 1'b0;
    if (kind == rptc_pkg::K_TAG_INT) begin
      tag_sync = word_i[27:24] != {chan_q, pos[1:0]};
    end else if (kind == rptc_pkg::K_TAG_PLAIN) begin
      if (!chan_ok) tag_sync = 1'b1;
      else if (!first_q) begin
        if (seq == lseq_q) tag_sync = 1'b1;
        else if ({1'b0, seq} != {1'b0, lseq_q} + 31'd1) tag_drop = 1'b1;
      end
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_valid_i && cfg_index_i <= rptc_pkg::REG_SUMS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= 1'b0;
      free_q  <= 1'b0;
      chan_q  <= 2'd0;
      gcnt_q  <= 11'd1;
      scnt_q  <= 16'd1;
      pos_q   <= '0;
      first_q <= 1'b1;
      lseq_q  <= '0;
      sync_q  <= '0;
      drop_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rptc_pkg::REG_INTEGRATE: integ_q <= cfg_data_i[0];
          rptc_pkg::REG_FREE_RUN:  free_q  <= cfg_data_i[0];
          rptc_pkg::REG_CHANNEL:   chan_q  <= cfg_data_i[1:0];
          rptc_pkg::REG_GATES:     gcnt_q  <= cfg_data_i[10:0];
          rptc_pkg::REG_SUMS:      scnt_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cfg_hit) pos_q <= '0;
      else if (cmd_i.accept) pos_q <= pos_d;
      if (cmd_i.accept) begin
        if (tag_sync) sync_q <= sync_q + 32'd1;
        if (tag_drop) drop_q <= drop_q + 32'd1;
        if (kind == rptc_pkg::K_TAG_PLAIN && chan_ok) begin
          first_q <= 1'b0;
          lseq_q  <= seq;
        end
      end
    end
  end

  logic out_valid_q;
  logic [9:0]  og_q;
  logic [15:0] oi_q, oq_q;
  logic        ol_q;
  logic [31:0] os_q, od_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      word_q <= word_i;
      gate_q <= 10'(gate);
      last_q <= (gate + PW'(1)) == g;
      if (kind == rptc_pkg::K_ODD_I) odd_i_q <= word_i;
      if (kind == rptc_pkg::K_GATE) begin
        res_i_q <= word_i[15:0];
        res_q_q <= word_i[31:16];
      end
    end
    if (cmd_i.cap_even) even_i_q <= rdata;
    if (cmd_i.load_i) even_q_q <= rdata;
    if (cmd_i.load_i || cmd_i.load_q) begin
      quo_q <= mag;
      neg_q <= sum[32];
      rem_q <= '0;
      cnt_q <= '0;
      dvs_q <= (scnt_q == 16'd0) ? 16'd1 : scnt_q;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 6'd1;
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_q <= rem_sh - {1'b0, dvs_q};
        quo_q <= {quo_q[31:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[31:0], 1'b0};
      end
    end
    if (cmd_i.store_i) res_i_q <= rptc_pkg::sat16(neg_q, quo_q);
    if (cmd_i.store_q) res_q_q <= rptc_pkg::sat16(neg_q, quo_q);
    if (cmd_i.out_load) begin
      og_q <= gate_q;
      oi_q <= res_i_q;
      oq_q <= res_q_q;
      ol_q <= last_q;
      os_q <= sync_q;
      od_q <= drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  assign stat_o.kind     = kind;
  assign stat_o.div_done = cnt_q == rptc_pkg::DIV_STEPS;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_gate_o  = og_q;
  assign out_i_o     = oi_q;
  assign out_q_o     = oq_q;
  assign out_last_o  = ol_q;
  assign out_sync_o  = os_q;
  assign out_drop_o  = od_q;

  `RPTC_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd_i.out_load, !out_valid_q || out_ready_i)
  `RPTC_ASSERT_IMP(a_sync_step, clk_i, rst_ni, sync_q != $past(sync_q),
                   sync_q == $past(sync_q) + 32'd1)
  `RPTC_ASSERT_IMP(a_drop_step, clk_i, rst_ni, drop_q != $past(drop_q),
                   drop_q == $past(drop_q) + 32'd1)

endmodule

// File: sv/radar_pulse_tag_checker_combiner_top.sv
// Radar pulse tag checker and even/odd combiner, top level.
// Tag and even words: one beat per cycle. Odd I word: the even word is captured in
// S_CAP before the next beat. Plain gate word: loaded into the output register in S_OUT.
// Integrated odd Q word: two 33-step serial divisions, then the load in S_OUT. No new
// beat is taken outside idle; a held output stalls the input. Async active-low reset
// clears control state, counters and config; the even store has no clear.
module radar_pulse_tag_checker_combiner_top #(
  parameter int unsigned MaxGates = rptc_pkg::MAX_GATES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // data_word
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // gate_index, i_value, q_value, sync_errors, dropped_pulses, zero pad
  output logic [111:0]                    m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rptc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rptc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rptc_pkg::ctrl_cmd_t cmd;
  rptc_pkg::dp_stat_t  stat;
  logic [9:0]  gate;
  logic [15:0] iv, qv;
  logic [31:0] se, dp;

  rptc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rptc_dp #(.MaxGates(MaxGates)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .word_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_gate_o  (gate),
    .out_i_o     (iv),
    .out_q_o     (qv),
    .out_last_o  (m_axis_tlast),
    .out_sync_o  (se),
    .out_drop_o  (dp)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {6'd0, dp, se, qv, iv, gate};

endmodule

// File: verif/tb_radar_pulse_tag_checker_combiner_top.sv
// Testbench for the radar pulse tag checker and combiner top level.
// Predicts gate results with a scoreboard class; depends on rptc_pkg and the top RTL.
`timescale 1ns / 100ps

module tb_radar_pulse_tag_checker_combiner_top;

  localparam int unsigned NGATES = 1024;
  localparam int unsigned LIMIT  = 1000000;
  localparam int unsigned ITEMS  = 1150;

  typedef struct packed {
    logic [31:0] dropped;
    logic [31:0] sync;
    logic [15:0] q;
    logic [15:0] i;
    logic [9:0]  gate;
    logic        last;
  } gate_beat_t;

  class pulse_scoreboard;
    logic        integ, free_run;
    logic [1:0]  chan;
    logic [10:0] gates;
    logic [15:0] sums;
    int unsigned pos;
    logic        first;
    logic [29:0] last_seq;
    logic [31:0] sync_cnt, drop_cnt;
    logic [31:0] even_mem [2*NGATES];
    logic [31:0] odd_i;
    gate_beat_t  expected_q [$];
    int          errors;

    function new();
      integ = 0; free_run = 0; chan = 0; gates = 1; sums = 1; pos = 0; first = 1;
      last_seq = 0; sync_cnt = 0; drop_cnt = 0; odd_i = 0; errors = 0;
    endfunction

    function void write_reg(logic [rptc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        rptc_pkg::REG_INTEGRATE: integ = val[0];
        rptc_pkg::REG_FREE_RUN:  free_run = val[0];
        rptc_pkg::REG_CHANNEL:   chan = val[1:0];
        rptc_pkg::REG_GATES:     gates = val[10:0];
        rptc_pkg::REG_SUMS:      sums = val;
        default: return;
      endcase
      pos = 0;
    endfunction

    function int unsigned eff_gates();
      if (gates == 0) return 1;
      if (gates > NGATES) return NGATES;
      return gates;
    endfunction

    function logic [15:0] combine(logic [31:0] ev, logic [31:0] od);
      longint s, d, qt;
      s = longint'($signed(ev)) + longint'($signed(od));
      d = (sums == 0) ? 1 : longint'(sums);
      qt = s / d;
      if (qt > 32767) qt = 32767;
      if (qt < -32768) qt = -32768;
      return qt[15:0];
    endfunction

    function void note_word(logic [31:0] w);
      int unsigned g, len, p, k, gi, hdr;
      gate_beat_t b;
      g = eff_gates();
      p = pos;
      if (integ) begin
        len = 4 + 4 * g;
        if (p >= len) p = 0;
        pos = (p + 1 >= len) ? 0 : p + 1;
        if (p < 4) begin
          if (w[27:24] != {chan, p[1:0]}) sync_cnt++;
        end else if (p < 4 + 2 * g) begin
          even_mem[p - 4] = w;
        end else begin
          k = p - 4 - 2 * g;
          gi = k >> 1;
          if (!k[0]) begin
            odd_i = w;
          end else begin
            b.gate = gi[9:0];
            b.i = combine(even_mem[2*gi], odd_i);
            b.q = combine(even_mem[2*gi+1], w);
            b.last = (gi + 1 == g);
            b.sync = sync_cnt;
            b.dropped = drop_cnt;
            expected_q.push_back(b);
          end
        end
      end else begin
        hdr = free_run ? 0 : 1;
        len = hdr + g;
        if (p >= len) p = 0;
        pos = (p + 1 >= len) ? 0 : p + 1;
        if (p < hdr) begin
          if (w[31:30] != chan) begin
            sync_cnt++;
          end else begin
            if (first) first = 0;
            else if (w[29:0] == last_seq) sync_cnt++;
            else if ({1'b0, w[29:0]} != {1'b0, last_seq} + 31'd1) drop_cnt++;
            last_seq = w[29:0];
          end
        end else begin
          gi = p - hdr;
          b.gate = gi[9:0];
          b.i = w[15:0];
          b.q = w[31:16];
          b.last = (gi + 1 == g);
          b.sync = sync_cnt;
          b.dropped = drop_cnt;
          expected_q.push_back(b);
        end
      end
    endfunction

    function void check_beat(logic [111:0] data, logic last);
      gate_beat_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data[9:0] != e.gate) begin
        $display("%0t: gate exp %0d got %0d", $time, e.gate, data[9:0]); errors++;
      end
      if (data[25:10] != e.i) begin
        $display("%0t: i exp %h got %h", $time, e.i, data[25:10]); errors++;
      end
      if (data[41:26] != e.q) begin
        $display("%0t: q exp %h got %h", $time, e.q, data[41:26]); errors++;
      end
      if (data[73:42] != e.sync) begin
        $display("%0t: sync exp %0d got %0d", $time, e.sync, data[73:42]); errors++;
      end
      if (data[105:74] != e.dropped) begin
        $display("%0t: dropped exp %0d got %0d", $time, e.dropped, data[105:74]); errors++;
      end
      if (last != e.last) begin
        $display("%0t: last exp %b got %b", $time, e.last, last); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i, cfg_ready_o;
  logic [rptc_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [rptc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  pulse_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  logic no_idle = 0;
  logic stall_req = 0;
  logic [29:0] gen_seq = 0;
  logic [31:0] word_q [$];

  radar_pulse_tag_checker_combiner_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial clk_i = 0;
  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tlast);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        m_axis_tready <= 0;
        repeat (400) @(posedge clk_i);
        stall_req = 0;
      end else if (pick_gap() == 0) begin
        m_axis_tready <= 1;
      end else begin
        m_axis_tready <= 0;
      end
    end
  end

  task automatic write_reg(logic [rptc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_words();
    int unsigned gap;
    while (word_q.size() > 0) begin
      s_axis_tvalid <= 1;
      s_axis_tdata  <= word_q.pop_front();
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 0;
  endtask

  task automatic drain();
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_component();
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(0, 1)) v = -v;
    if ($urandom_range(0, 19) == 0) v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    return v;
  endfunction

  function automatic logic [31:0] plain_tag();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) gen_seq = gen_seq + 30'd1;
    else if (r < 86) gen_seq = 30'($urandom);
    else if (r < 88) gen_seq = 30'h3fffffff;
    if (r >= 93) return {sb.chan + 2'($urandom_range(1, 3)), 30'($urandom)};
    return {sb.chan, gen_seq};
  endfunction

  task automatic build_records(int unsigned n);
    int unsigned g, len, cut;
    logic [31:0] w;
    g = sb.eff_gates();
    for (int unsigned r = 0; r < n; r++) begin
      len = sb.integ ? 4 + 4 * g : (sb.free_run ? 0 : 1) + g;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
      for (int unsigned p = 0; p < cut; p++) begin
        if (sb.integ && p < 4) begin
          w = $urandom;
          if ($urandom_range(0, 9) != 0) w[27:24] = {sb.chan, p[1:0]};
        end else if (sb.integ) begin
          w = rand_component();
        end else if (!sb.free_run && p == 0) begin
          w = plain_tag();
        end else begin
          w = $urandom;
        end
        word_q.push_back(w);
      end
    end
  endtask

  initial begin
    int unsigned phase;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    cfg_valid_i = 0;
    cfg_index_i = rptc_pkg::REG_INTEGRATE;
    cfg_data_i = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // plain tags: in order, repeat, gap, wrong channel, wrap
    word_q = '{32'h0000_0005, 32'h8000_7fff, 32'h0000_0006, 32'hffff_ffff,
               32'h0000_0006, 32'h0000_0000, 32'h0000_0009, 32'h1234_5678,
               32'hc000_000a, 32'h7fff_8000, 32'h3fff_ffff, 32'h0001_0001,
               32'h0000_0000, 32'hffff_0000};
    send_words();
    drain();

    write_reg(rptc_pkg::REG_FREE_RUN, 1);
    write_reg(rptc_pkg::REG_GATES, 0);
    word_q = '{32'haaaa_5555, 32'h5555_aaaa};
    send_words();
    drain();

    write_reg(rptc_pkg::REG_INTEGRATE, 1);
    write_reg(rptc_pkg::REG_CHANNEL, 3);
    write_reg(rptc_pkg::REG_GATES, 2);
    write_reg(rptc_pkg::REG_SUMS, 0);
    word_q = '{32'h0c00_0000, 32'h0d00_0000, 32'h0000_0000, 32'h0f00_0000,
               32'h7fff_ffff, 32'h8000_0000, 32'h0000_8000, 32'hffff_7fff,
               32'h7fff_ffff, 32'h8000_0000, 32'hffff_8001, 32'h0000_0003};
    send_words();
    drain();

    write_reg(rptc_pkg::REG_SUMS, 16'hffff);
    word_q = '{32'h0c00_0000, 32'h0d00_0000, 32'h0e00_0000, 32'h0f00_0000,
               32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hfffe_ffff,
               32'h7fff_ffff, 32'h8000_0000, 32'h0000_ffff, 32'hffff_0001};
    send_words();
    drain();

    // largest gate count, plain with tag
    write_reg(rptc_pkg::REG_INTEGRATE, 0);
    write_reg(rptc_pkg::REG_FREE_RUN, 0);
    write_reg(rptc_pkg::REG_CHANNEL, 1);
    write_reg(rptc_pkg::REG_GATES, 16'h07ff);
    build_records(1);
    send_words();
    drain();

    phase = 0;
    while (words_sent < ITEMS) begin
      if ($urandom_range(0, 9) < 7)
        write_reg(rptc_pkg::REG_INTEGRATE, 16'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) < 7)
        write_reg(rptc_pkg::REG_FREE_RUN, 16'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) < 7)
        write_reg(rptc_pkg::REG_CHANNEL, 16'($urandom_range(0, 3)));
      write_reg(rptc_pkg::REG_GATES,
                ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 5)));
      case ($urandom_range(0, 4))
        0: write_reg(rptc_pkg::REG_SUMS, 0);
        1: write_reg(rptc_pkg::REG_SUMS, 1);
        2: write_reg(rptc_pkg::REG_SUMS, 16'hffff);
        default: write_reg(rptc_pkg::REG_SUMS,
                           16'($urandom_range(1, 65535) >> $urandom_range(0, 15)));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      build_records($urandom_range(3, 12));
      if (phase == 0) begin
        write_reg(rptc_pkg::REG_INTEGRATE, 0);
        build_records(20);
        stall_req = 1;
      end
      send_words();
      drain();
      phase++;
    end

    if (sb.expected_q.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/rptc_pkg.sv
sv/rptc_ram.sv
sv/rptc_ctrl.sv
sv/rptc_dp.sv
sv/radar_pulse_tag_checker_combiner_top.sv
verif/tb_radar_pulse_tag_checker_combiner_top.sv
